// ===== design/qdnr_pkg.sv =====
// Package for the quantized dense neuron with requantization.
// Widths, register indexes, configuration struct and the back-end state type.
// No dependencies.
`timescale 1ns / 1ps

package qdnr_pkg;

   // Datapath widths
   localparam int ACC_W      = 32;
   localparam int DIFF_W     = 10;
   localparam int PROD_W     = 20;
   localparam int ZP_W       = 9;
   localparam int MULT_W     = 15;
   localparam int SHIFT_W    = 5;
   localparam int OUT_W      = 8;
   localparam int Q_SHIFT    = 15;

   // Queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Reset value of the Q15 multiplier (one half)
   localparam logic [MULT_W-1:0] MULT_RESET = 15'd16384;

   // Rounding nudges of the high multiply
   localparam logic [ACC_W-1:0] NUDGE_POS = 32'h0000_4000;
   localparam logic [ACC_W-1:0] NUDGE_NEG = 32'hFFFF_C001;

   // Output clamp limit
   localparam logic signed [ACC_W+1:0] OUT_MAX = 34'sd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_ZP  = 3'd0,
      CSR_WEIGHT_ZP = 3'd1,
      CSR_QUANT_MULT = 3'd2,
      CSR_SHIFT     = 3'd3,
      CSR_OUTPUT_ZP = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [ZP_W-1:0]  input_zp;
      logic signed [ZP_W-1:0]  weight_zp;
      logic [MULT_W-1:0]       quant_mult;
      logic [SHIFT_W-1:0]      shift_amt;
      logic signed [ZP_W-1:0]  output_zp;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_NUDGE,
      BK_SCALE,
      BK_SHIFT,
      BK_CLAMP,
      BK_HOLD
   } back_state_type;

endpackage

// ===== design/qdnr_if.sv =====
// Channel interfaces of the neuron block: item input, result output, register writes.
// Depends on qdnr_pkg for widths.
`timescale 1ns / 1ps

interface qdnr_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         activation;
   logic [7:0]         weight;
   logic signed [31:0] bias;
   logic               is_last;

   modport source (output valid, activation, weight, bias, is_last, input ready);
   modport sink   (input valid, activation, weight, bias, is_last, output ready);
endinterface

interface qdnr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [qdnr_pkg::OUT_W-1:0] out_value;

   modport source (output valid, out_value, input ready);
   modport sink   (input valid, out_value, output ready);
endinterface

interface qdnr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [qdnr_pkg::CSR_IDX_W-1:0]  index;
   logic [qdnr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/quantized_dense_neuron_requant_top.sv =====
// Quantized dense neuron with int8-style requantization.
// Throughput: one input word per cycle while the two-entry queue has room; the
//   requantizer handles one neuron at a time and holds its result until it is taken.
// Path: queue, then back-end states IDLE, MUL, NUDGE, SCALE, SHIFT, CLAMP; valid in HOLD.
// Reset: synchronous; clears accumulator, queue, sequencer and registers to defaults.
// Depends on qdnr_pkg, qdnr_if, qdnr_front, qdnr_fifo, qdnr_back.
`timescale 1ns / 1ps

module quantized_dense_neuron_requant_top (
   input  logic       clock,
   input  logic       reset,
   qdnr_req_if.sink   req_ch,
   qdnr_rsp_if.source rsp_ch,
   qdnr_csr_if.sink   csr_ch
);

   qdnr_pkg::cfg_type                cfg_ff, cfg_in;
   logic                             push_valid;
   logic                             push_ready;
   logic [qdnr_pkg::ACC_W-1:0]       push_data;
   logic                             pop;
   logic                             pop_valid;
   logic [qdnr_pkg::ACC_W-1:0]       pop_data;
   logic [qdnr_pkg::FIFO_CNT_W-1:0]  fifo_count;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            qdnr_pkg::CSR_INPUT_ZP:   cfg_in.input_zp   = csr_ch.data[qdnr_pkg::ZP_W-1:0];
            qdnr_pkg::CSR_WEIGHT_ZP:  cfg_in.weight_zp  = csr_ch.data[qdnr_pkg::ZP_W-1:0];
            qdnr_pkg::CSR_QUANT_MULT: cfg_in.quant_mult = csr_ch.data[qdnr_pkg::MULT_W-1:0];
            qdnr_pkg::CSR_SHIFT:      cfg_in.shift_amt  = csr_ch.data[qdnr_pkg::SHIFT_W-1:0];
            qdnr_pkg::CSR_OUTPUT_ZP:  cfg_in.output_zp  = csr_ch.data[qdnr_pkg::ZP_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_zp   <= '0;
         cfg_ff.weight_zp  <= '0;
         cfg_ff.quant_mult <= qdnr_pkg::MULT_RESET;
         cfg_ff.shift_amt  <= '0;
         cfg_ff.output_zp  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Multiply-accumulate front end
   qdnr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Queue of finished sums
   qdnr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .count      (fifo_count)
   );

   // Requantizing back end
   qdnr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

   // Queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= qdnr_pkg::FIFO_CNT_W'(qdnr_pkg::FIFO_DEPTH))
      else $error("queue count above depth");

   // A last word with no pop in flight grows the queue by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (fifo_count == $past(fifo_count) + 1'b1))
      else $error("last word not queued");

   // Reset leaves no result and an empty queue
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_ch.valid && fifo_count == '0))
      else $error("state not cleared by reset");

endmodule

// ===== design/qdnr_front.sv =====
// Front end: takes input words, does the multiply-accumulate, and on the last
// word pushes accumulator plus bias into the queue. Depends on qdnr_pkg, qdnr_if.
`timescale 1ns / 1ps

module qdnr_front (
   input  logic                     clock,
   input  logic                     reset,
   qdnr_req_if.sink                 req,
   input  qdnr_pkg::cfg_type        cfg,
   input  logic                     push_ready,
   output logic                     push_valid,
   output logic [qdnr_pkg::ACC_W-1:0] push_data
);

   logic [qdnr_pkg::ACC_W-1:0]          acc_ff;
   logic [qdnr_pkg::ACC_W-1:0]          acc_in;
   logic signed [qdnr_pkg::DIFF_W-1:0]  act_diff;
   logic signed [qdnr_pkg::DIFF_W-1:0]  wgt_diff;
   logic signed [qdnr_pkg::PROD_W-1:0]  prod;
   logic [qdnr_pkg::ACC_W-1:0]          sum;
   logic                                accept;

   // Every word waits for queue room so results keep their order
   assign req.ready = push_ready;
   assign accept    = req.valid && req.ready;

   // Offset-corrected product, sign-extended into the wrapping accumulator
   always_comb begin
      act_diff = $signed({2'b00, req.activation}) - $signed({cfg.input_zp[8], cfg.input_zp});
      wgt_diff = $signed({2'b00, req.weight}) - $signed({cfg.weight_zp[8], cfg.weight_zp});
      prod     = act_diff * wgt_diff;
      sum      = acc_ff + {{(qdnr_pkg::ACC_W-qdnr_pkg::PROD_W){prod[qdnr_pkg::PROD_W-1]}},
                           prod};
   end

   // Hand the biased sum to the back end on the last word
   assign push_valid = accept && req.is_last;
   assign push_data  = sum + req.bias;

   // Accumulator clears after each neuron
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req.is_last ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== design/qdnr_fifo.sv =====
// Short queue of biased accumulator words between front and back end.
// Depends on qdnr_pkg.
`timescale 1ns / 1ps

module qdnr_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [qdnr_pkg::ACC_W-1:0]      push_data,
   output logic                            push_ready,
   input  logic                            pop,
   output logic                            pop_valid,
   output logic [qdnr_pkg::ACC_W-1:0]      pop_data,
   output logic [qdnr_pkg::FIFO_CNT_W-1:0] count
);

   logic [qdnr_pkg::ACC_W-1:0]      mem_ff [qdnr_pkg::FIFO_DEPTH];
   logic [qdnr_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [qdnr_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [qdnr_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            do_push, do_pop;

   assign push_ready = (count_ff != qdnr_pkg::FIFO_CNT_W'(qdnr_pkg::FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/qdnr_back.sv =====
// Back end: requantizes one biased sum at a time (Q15 high multiply, rounding
// shift, offset and clamp) and holds the result word. Depends on qdnr_pkg, qdnr_if.
`timescale 1ns / 1ps

module qdnr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  qdnr_pkg::cfg_type          cfg,
   input  logic                       pop_valid,
   input  logic [qdnr_pkg::ACC_W-1:0] pop_data,
   output logic                       pop,
   qdnr_rsp_if.source                 rsp
);

   qdnr_pkg::back_state_type          state_ff, state_in;
   logic [qdnr_pkg::ACC_W-1:0]        data_ff, data_in;
   logic [qdnr_pkg::OUT_W-1:0]        out_ff, out_in;
   logic signed [2*qdnr_pkg::ACC_W-1:0] mul_full;
   logic signed [qdnr_pkg::ACC_W-1:0] scaled;
   logic [qdnr_pkg::ACC_W-1:0]        mask;
   logic [qdnr_pkg::ACC_W-1:0]        rem;
   logic [qdnr_pkg::ACC_W-1:0]        thr;
   logic [qdnr_pkg::ACC_W-1:0]        floor_q;
   logic signed [qdnr_pkg::ACC_W+1:0] biased;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qdnr_pkg::BK_IDLE:  if (pop_valid) state_in = qdnr_pkg::BK_MUL;
         qdnr_pkg::BK_MUL:   state_in = qdnr_pkg::BK_NUDGE;
         qdnr_pkg::BK_NUDGE: state_in = qdnr_pkg::BK_SCALE;
         qdnr_pkg::BK_SCALE: state_in = qdnr_pkg::BK_SHIFT;
         qdnr_pkg::BK_SHIFT: state_in = qdnr_pkg::BK_CLAMP;
         qdnr_pkg::BK_CLAMP: state_in = qdnr_pkg::BK_HOLD;
         qdnr_pkg::BK_HOLD:  if (rsp.ready) state_in = qdnr_pkg::BK_IDLE;
         default:            state_in = qdnr_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop       = (state_ff == qdnr_pkg::BK_IDLE) && pop_valid;
      rsp.valid = (state_ff == qdnr_pkg::BK_HOLD);
   end
   assign rsp.out_value = out_ff;

   // Arithmetic pieces, one used per step
   always_comb begin
      // multiplier is non-negative, so the saturating corner never occurs
      mul_full = $signed(data_ff) * $signed({{(qdnr_pkg::ACC_W-qdnr_pkg::MULT_W){1'b0}},
                                              cfg.quant_mult});
      scaled   = $signed(data_ff) >>> qdnr_pkg::Q_SHIFT;
      mask     = (qdnr_pkg::ACC_W'(1) << cfg.shift_amt) - 1'b1;
      rem      = data_ff & mask;
      thr      = {1'b0, mask[qdnr_pkg::ACC_W-1:1]} +
                 {{(qdnr_pkg::ACC_W-1){1'b0}}, data_ff[qdnr_pkg::ACC_W-1]};
      floor_q  = $signed(data_ff) >>> cfg.shift_amt;
      biased   = $signed({{2{data_ff[qdnr_pkg::ACC_W-1]}}, data_ff}) +
                 $signed({{(qdnr_pkg::ACC_W+2-qdnr_pkg::ZP_W){cfg.output_zp[8]}},
                          cfg.output_zp});
   end

   // Datapath register steps
   always_comb begin
      data_in = data_ff;
      out_in  = out_ff;
      unique case (state_ff)
         qdnr_pkg::BK_IDLE: begin
            data_in = pop_data;
         end
         qdnr_pkg::BK_MUL: begin
            data_in = mul_full[qdnr_pkg::ACC_W-1:0];
         end
         qdnr_pkg::BK_NUDGE: begin
            data_in = data_ff + (data_ff[qdnr_pkg::ACC_W-1] ? qdnr_pkg::NUDGE_NEG
                                                            : qdnr_pkg::NUDGE_POS);
         end
         qdnr_pkg::BK_SCALE: begin
            // divide by 2^15 rounding toward zero
            data_in = scaled +
                      {{(qdnr_pkg::ACC_W-1){1'b0}},
                       data_ff[qdnr_pkg::ACC_W-1] && (|data_ff[qdnr_pkg::Q_SHIFT-1:0])};
         end
         qdnr_pkg::BK_SHIFT: begin
            data_in = floor_q + {{(qdnr_pkg::ACC_W-1){1'b0}}, (rem > thr)};
         end
         qdnr_pkg::BK_CLAMP: begin
            priority if (biased[qdnr_pkg::ACC_W+1]) begin
               out_in = '0;
            end else if (biased > qdnr_pkg::OUT_MAX) begin
               out_in = qdnr_pkg::OUT_MAX[qdnr_pkg::OUT_W-1:0];
            end else begin
               out_in = biased[qdnr_pkg::OUT_W-1:0];
            end
         end
         qdnr_pkg::BK_HOLD: begin
            data_in = data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qdnr_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      out_ff  <= out_in;
   end

endmodule

// ===== tb/quantized_dense_neuron_requant_top_tb.sv =====
// Testbench for quantized_dense_neuron_requant_top: directed table, then random neurons under
// random register settings; each result is checked against a known value or inline predictor.
// Depends on qdnr_pkg, the qdnr_*_if interfaces and the design under test.
`timescale 1ns / 1ps

module quantized_dense_neuron_requant_top_tb;

   localparam int TOTAL_WORDS = 1050;
   localparam int SETTLE      = 12;
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int PLAN_ROWS   = 31;
   localparam int PRESSURE_PHASE = 3;

   // One row of the directed plan: either a full register set or one input word
   typedef struct packed {
      logic        is_cfg;
      logic [15:0] w_izp;
      logic [15:0] w_wzp;
      logic [15:0] w_mult;
      logic [15:0] w_shift;
      logic [15:0] w_ozp;
      logic [7:0]  act;
      logic [7:0]  wgt;
      logic [31:0] bias;
      logic        last;
      logic        has_known;
      logic [7:0]  known;
   } plan_row_type;

   logic clock;
   logic reset;

   qdnr_req_if req_ch ();
   qdnr_rsp_if rsp_ch ();
   qdnr_csr_if csr_ch ();

   quantized_dense_neuron_requant_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor copy of the registers and the running dot product
   logic signed [qdnr_pkg::ZP_W-1:0] cfg_izp   = '0;
   logic signed [qdnr_pkg::ZP_W-1:0] cfg_wzp   = '0;
   logic [qdnr_pkg::MULT_W-1:0]      cfg_mult  = 15'd16384;
   logic [qdnr_pkg::SHIFT_W-1:0]     cfg_shift = '0;
   logic signed [qdnr_pkg::ZP_W-1:0] cfg_ozp   = '0;
   logic [31:0]                      acc_sum   = '0;

   logic [7:0] pending_out [$];
   int         mismatches = 0;
   int         results_seen = 0;
   int         words_sent = 0;
   int         next_gap = 0;
   bit         req_up = 1'b0;
   bit         burst = 1'b0;
   bit         long_hold_pending = 1'b0;
   int         stall_cycles = 0;

   plan_row_type plan [PLAN_ROWS];

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.activation <= '0;
      req_ch.weight     <= '0;
      req_ch.bias       <= '0;
      req_ch.is_last    <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= '0;
      csr_ch.data       <= '0;
   end

   // Signed product of the offset-corrected bytes
   function automatic int dot_term(logic [7:0] act, logic [7:0] wgt);
      int da;
      int dw;
      da = int'(act) - int'(cfg_izp);
      dw = int'(wgt) - int'(cfg_wzp);
      return da * dw;
   endfunction

   // High multiply, rounding shift, offset and clamp of a finished accumulator
   function automatic logic [7:0] requantize(logic [31:0] total);
      logic signed [31:0] a;
      logic signed [31:0] prod;
      logic signed [31:0] sum;
      logic signed [31:0] v;
      logic signed [31:0] fl;
      logic [31:0]        mask;
      logic [31:0]        rem;
      logic [31:0]        thr;
      int                 r;
      a    = total;
      prod = a * $signed({17'd0, cfg_mult});
      sum  = prod + ((prod < 0) ? -32'sd16383 : 32'sd16384);
      v    = sum / 32'sd32768;
      // round half away from zero; negative values need one more unit of threshold
      mask = (32'd1 << cfg_shift) - 32'd1;
      rem  = v & mask;
      thr  = (mask >> 1) + ((v < 0) ? 32'd1 : 32'd0);
      fl   = v >>> cfg_shift;
      v    = fl + ((rem > thr) ? 32'sd1 : 32'sd0);
      r    = int'(v) + int'(cfg_ozp);
      if (r < 0) r = 0;
      else if (r > 255) r = 255;
      return r[7:0];
   endfunction

   function automatic void apply_reg(qdnr_pkg::csr_idx_type idx, logic [15:0] word);
      case (idx)
         qdnr_pkg::CSR_INPUT_ZP:   cfg_izp   = word[qdnr_pkg::ZP_W-1:0];
         qdnr_pkg::CSR_WEIGHT_ZP:  cfg_wzp   = word[qdnr_pkg::ZP_W-1:0];
         qdnr_pkg::CSR_QUANT_MULT: cfg_mult  = word[qdnr_pkg::MULT_W-1:0];
         qdnr_pkg::CSR_SHIFT:      cfg_shift = word[qdnr_pkg::SHIFT_W-1:0];
         qdnr_pkg::CSR_OUTPUT_ZP:  cfg_ozp   = word[qdnr_pkg::ZP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int draw_gap();
      if (burst) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic plan_row_type word_row(logic [7:0] act, logic [7:0] wgt,
                                             logic [31:0] bias, logic last,
                                             logic has_known, logic [7:0] known);
      plan_row_type row;
      row = '0;
      row.act = act;
      row.wgt = wgt;
      row.bias = bias;
      row.last = last;
      row.has_known = has_known;
      row.known = known;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(logic [15:0] w_izp, logic [15:0] w_wzp,
                                            logic [15:0] w_mult, logic [15:0] w_shift,
                                            logic [15:0] w_ozp);
      plan_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.w_izp = w_izp;
      row.w_wzp = w_wzp;
      row.w_mult = w_mult;
      row.w_shift = w_shift;
      row.w_ozp = w_ozp;
      return row;
   endfunction

   // Register word with random upper bits above the field
   function automatic logic [15:0] reg_word(int value, int width);
      logic [15:0] mask;
      logic [15:0] w;
      mask = (16'd1 << width) - 16'd1;
      w = 16'($urandom);
      return (w & ~mask) | (16'(value) & mask);
   endfunction

   function automatic int pick_zp();
      case ($urandom_range(0, 5))
         0: return -256;
         1: return 255;
         2: return 0;
         default: return int'($urandom_range(0, 511)) - 256;
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_bias();
      case ($urandom_range(0, 2))
         0: return $urandom;
         1: return 32'(int'($urandom_range(0, 131071)) - 65536);
         default: return 32'd0;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("%0t: result %0d %s: out_value %0d, expected %0d",
               $time, results_seen, what, got, want);
   endtask

   // Offer one input word and fold it into the predictor once accepted
   task automatic send_word(logic [7:0] act, logic [7:0] wgt, logic [31:0] bias,
                            logic last, logic has_known, logic [7:0] known);
      repeat (next_gap) @(posedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.activation <= act;
      req_ch.weight     <= wgt;
      req_ch.bias       <= bias;
      req_ch.is_last    <= last;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      acc_sum = acc_sum + dot_term(act, wgt);
      if (last) begin
         acc_sum = acc_sum + bias;
         pending_out.push_back(has_known ? known : requantize(acc_sum));
         acc_sum = '0;
      end
      next_gap = draw_gap();
      if (next_gap > 0) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Stop offering, wait for every expected word, then let the back end go quiet
   task automatic settle_results();
      if (req_up) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_regs(logic [15:0] w_izp, logic [15:0] w_wzp, logic [15:0] w_mult,
                               logic [15:0] w_shift, logic [15:0] w_ozp);
      logic [15:0]            words [5];
      qdnr_pkg::csr_idx_type  order [5];
      words = '{w_izp, w_wzp, w_mult, w_shift, w_ozp};
      order = '{qdnr_pkg::CSR_INPUT_ZP, qdnr_pkg::CSR_WEIGHT_ZP, qdnr_pkg::CSR_QUANT_MULT,
                qdnr_pkg::CSR_SHIFT, qdnr_pkg::CSR_OUTPUT_ZP};
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= order[i];
         csr_ch.data  <= words[i];
         do @(posedge clock); while (!csr_ch.ready);
         apply_reg(order[i], words[i]);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Result side: random back-pressure, one long hold on request, check against the oldest word
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_out.size() == 0)
               report_mismatch("with none expected", rsp_ch.out_value, 8'hxx);
            else begin
               logic [7:0] want;
               want = pending_out.pop_front();
               if (rsp_ch.out_value !== want)
                  report_mismatch("wrong value", rsp_ch.out_value, want);
            end
            results_seen++;
            hold = draw_gap();
         end
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no accepted word on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("quantized_dense_neuron_requant_top_tb: FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      int phase;
      int neurons;
      int len;
      plan = '{
         // reset settings: plain product, half multiplier, no shift
         word_row(8'd0,   8'd0,   32'd0,          1'b1, 1'b1, 8'd0),
         word_row(8'd255, 8'd255, 32'd0,          1'b1, 1'b1, 8'd255),
         // bias on a word that is not last is ignored
         word_row(8'd255, 8'd0,   32'h7FFF_FFFF,  1'b0, 1'b0, 8'd0),
         word_row(8'd0,   8'd255, 32'd5,          1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'h8000_0000,  1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'h7FFF_FFFF,  1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'hFFFF_FF9C,  1'b1, 1'b1, 8'd0),
         word_row(8'd255, 8'd255, 32'd0,          1'b0, 1'b0, 8'd0),
         word_row(8'd255, 8'd255, 32'd0,          1'b1, 1'b1, 8'd255),
         // longer run: the multiply product wraps
         word_row(8'd255, 8'd255, 32'd0,          1'b0, 1'b0, 8'd0),
         word_row(8'd255, 8'd255, 32'd0,          1'b0, 1'b0, 8'd0),
         word_row(8'd255, 8'd255, 32'd0,          1'b0, 1'b0, 8'd0),
         word_row(8'd255, 8'd255, 32'hFFFF_0000,  1'b1, 1'b0, 8'd0),
         // extreme offsets, largest multiplier and shift
         cfg_row(16'hFF00, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFEFF),
         word_row(8'd255, 8'd0,   32'd0,          1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd255, 32'h8000_0000,  1'b1, 1'b0, 8'd0),
         word_row(8'd128, 8'd128, 32'd1,          1'b1, 1'b0, 8'd0),
         // zero multiplier leaves only the output offset
         cfg_row(16'h00FF, 16'h0100, 16'h0000, 16'h0000, 16'h0100),
         word_row(8'd0,   8'd255, 32'h1234_5678,  1'b1, 1'b1, 8'd0),
         cfg_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF),
         word_row(8'd17,  8'd200, 32'h7FFF_FFFF,  1'b1, 1'b1, 8'd255),
         // rounding shift on both signs near the half point
         cfg_row(16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 16'h0080),
         word_row(8'd0,   8'd0,   32'd3,          1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'hFFFF_FFFD,  1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'd5,          1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'hFFFF_FFFB,  1'b1, 1'b0, 8'd0),
         cfg_row(16'h0000, 16'h0000, 16'h4000, 16'h0004, 16'h0000),
         word_row(8'd0,   8'd0,   32'd24,         1'b1, 1'b0, 8'd0),
         word_row(8'd0,   8'd0,   32'hFFFF_FFD0,  1'b1, 1'b0, 8'd0),
         word_row(8'd255, 8'd255, 32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0),
         word_row(8'd1,   8'd1,   32'd0,          1'b1, 1'b0, 8'd0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            settle_results();
            program_regs(plan[i].w_izp, plan[i].w_wzp, plan[i].w_mult,
                         plan[i].w_shift, plan[i].w_ozp);
         end else begin
            send_word(plan[i].act, plan[i].wgt, plan[i].bias, plan[i].last,
                      plan[i].has_known, plan[i].known);
         end
      end

      // random phases, each under a fresh register set
      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         settle_results();
         program_regs(reg_word(pick_zp(), qdnr_pkg::ZP_W),
                      reg_word(pick_zp(), qdnr_pkg::ZP_W),
                      reg_word(($urandom_range(0, 3) == 0) ? 32767 * $urandom_range(0, 1)
                                                            : $urandom_range(0, 32767),
                               qdnr_pkg::MULT_W),
                      reg_word(($urandom_range(0, 3) == 0) ? 31 * $urandom_range(0, 1)
                                                            : $urandom_range(0, 31),
                               qdnr_pkg::SHIFT_W),
                      reg_word(pick_zp(), qdnr_pkg::ZP_W));
         burst = ($urandom_range(0, 3) == 0);
         if (phase == PRESSURE_PHASE) begin
            // receiver stalls long while words keep coming back to back
            burst = 1'b1;
            next_gap = 0;
            long_hold_pending = 1'b1;
            neurons = 20;
         end else begin
            neurons = $urandom_range(4, 12);
         end
         for (int n = 0; n < neurons; n++) begin
            if (phase == PRESSURE_PHASE)
               len = $urandom_range(1, 3);
            else if ($urandom_range(0, 9) == 0)
               len = $urandom_range(9, 40);
            else
               len = $urandom_range(1, 8);
            for (int k = 1; k <= len; k++)
               send_word(pick_byte(), pick_byte(), pick_bias(), k == len, 1'b0, 8'd0);
            // occasionally pause the sender until everything has come back
            if ($urandom_range(0, 15) == 0) settle_results();
         end
         phase++;
      end

      settle_results();
      if (mismatches == 0)
         $display("quantized_dense_neuron_requant_top_tb: PASS");
      else
         $display("quantized_dense_neuron_requant_top_tb: FAIL");
      $finish;
   end

endmodule
